### rtl/sit_pkg.sv
// shared types, constants and helpers for the sorted interval table
`timescale 1ns / 1ps
package sit_pkg;

  localparam int FRAME_BITS          = 32;
  localparam int TAG_BITS            = 16;
  localparam int END_BITS            = FRAME_BITS + 1;
  localparam int DEFAULT_TABLE_DEPTH = 64;
  localparam int MAX_RESULTS         = 64;
  localparam int RM_BITS             = $clog2(MAX_RESULTS + 1);

  typedef logic [FRAME_BITS-1:0] frame_t;
  typedef logic [END_BITS-1:0]   end_t;
  typedef logic [TAG_BITS-1:0]   tag_t;

  typedef enum logic [2:0] {
    ACT_INSERT     = 3'd0,
    ACT_OVERWRITE  = 3'd1,
    ACT_REMOVE     = 3'd2,
    ACT_LOOKUP     = 3'd3,
    ACT_FIND_FREE  = 3'd4,
    ACT_NEXT_START = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_OVERLAP = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_FULL    = 3'd3,
    ST_NONE    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

  typedef enum logic [2:0] {
    M_INSERT,
    M_TRIM,
    M_REMOVE,
    M_LOOKUP,
    M_FREE,
    M_NEXT
  } mode_e;

  // start is one bit wider: a front cut can push it past the frame range
  typedef struct packed {
    end_t   start;
    frame_t length;
    frame_t offset;
    tag_t   tag;
  } entry_t;

  typedef struct packed {
    status_e status;
    end_t    frame_value;
    frame_t  found_length;
    frame_t  found_offset;
    tag_t    found_tag;
    logic    last;
  } result_t;

  // running state of one pass over the table
  typedef struct packed {
    logic               decided;
    status_e            status;
    end_t               prev_end;
    logic [RM_BITS-1:0] rm_cnt;
    logic               hit_valid;
    entry_t             hit;
    end_t               cur;
    logic               done;
  } scan_t;

  typedef struct packed {
    mode_e  mode;
    frame_t req_start;
    frame_t req_len;
    frame_t req_off;
    tag_t   req_tag;
    entry_t x;
    logic   x_valid;
    logic   last_cycle;
    logic   table_full;
    logic   out_free;
    scan_t  scan;
  } head_in_t;

  typedef struct packed {
    scan_t   scan;
    logic    w0_en;
    entry_t  w0;
    logic    w1_en;
    entry_t  w1;
    logic    stall;
    logic    emit;
    result_t res;
  } head_out_t;

  typedef struct packed {
    logic shift;
    logic w0_hit;
    logic w1_hit;
  } cell_ctl_t;

  function automatic result_t entry_result(entry_t e, logic last);
    result_t r;
    r.status       = ST_OK;
    r.frame_value  = e.start;
    r.found_length = e.length;
    r.found_offset = e.offset;
    r.found_tag    = e.tag;
    r.last         = last;
    return r;
  endfunction

  function automatic result_t status_result(status_e st, end_t fv);
    result_t r;
    r              = '0;
    r.status       = st;
    r.frame_value  = fv;
    r.last         = 1'b1;
    return r;
  endfunction

endpackage

### rtl/sorted_interval_table.sv
// top level of the sorted interval table: cell chain, head unit and control
`timescale 1ns / 1ps
// Table of up to TABLE_DEPTH non-overlapping intervals kept sorted by start,
// held in a chain of cells with valid entries packed from cell 0. An action
// runs as a pass: the chain shifts toward cell 0 once a cycle while not
// stalled, the head unit looks at the entry that leaves cell 0 and writes it
// back (kept, trimmed, dropped, or with the new entry beside it) behind the
// entries still waiting, so the table is sorted again when the pass ends. A
// pass shifts every used entry out of cell 0 once; an overwrite takes two
// passes (trim, then insert), and a zero-length insert or overwrite makes no
// pass and goes straight to the result stage. A remove range pass stalls while
// the result register is still full, and the final result stage waits the same way.
// Input is accepted only between actions; a finished result may still wait
// in the output register while the next action starts.
// Unused action codes are accepted and dropped with no result.
module sorted_interval_table
  import sit_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            in_action,
  input  logic [FRAME_BITS-1:0] in_start_frame,
  input  logic [FRAME_BITS-1:0] in_length_frames,
  input  logic [FRAME_BITS-1:0] in_source_offset,
  input  logic [TAG_BITS-1:0]   in_entry_tag,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            out_status,
  output logic [END_BITS-1:0]   out_frame_value,
  output logic [FRAME_BITS-1:0] out_found_length,
  output logic [FRAME_BITS-1:0] out_found_offset,
  output logic [TAG_BITS-1:0]   out_found_tag,
  output logic                  out_last
);

  localparam int CNT_BITS = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_BITS = CNT_BITS + 1;

  // control state
  state_e              state_r, state_nxt;
  logic [CNT_BITS-1:0] n_r, n_nxt;       // used_count
  logic [CNT_BITS-1:0] k_r, k_nxt;       // entries written back this pass
  logic [CNT_BITS-1:0] rem_r, rem_nxt;   // shifts left in this pass after the current one
  logic                phase_r, phase_nxt;
  logic                out_valid_r, out_valid_nxt;

  // transaction payload held for the whole action
  action_e op_r, op_nxt;
  frame_t  rs_r, rs_nxt;
  frame_t  rl_r, rl_nxt;
  frame_t  ro_r, ro_nxt;
  tag_t    rt_r, rt_nxt;
  scan_t   scan_r, scan_nxt;
  result_t res_r, res_nxt;

  head_in_t  hi;
  head_out_t ho;
  mode_e     mode;
  logic      out_free;
  logic      scan_go;
  logic      wr0, wr1;
  logic [CNT_BITS-1:0] k_pass;
  logic [IDX_BITS-1:0] c0, c1;

  entry_t cell_q [TABLE_DEPTH];

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    unique case (op_r)
      ACT_INSERT:    mode = M_INSERT;
      ACT_OVERWRITE: mode = phase_r ? M_INSERT : M_TRIM;
      ACT_REMOVE:    mode = M_REMOVE;
      ACT_LOOKUP:    mode = M_LOOKUP;
      ACT_FIND_FREE: mode = M_FREE;
      default:       mode = M_NEXT;
    endcase
  end

  always_comb begin
    hi.mode       = mode;
    hi.req_start  = rs_r;
    hi.req_len    = rl_r;
    hi.req_off    = ro_r;
    hi.req_tag    = rt_r;
    hi.x          = cell_q[0];
    hi.x_valid    = (n_r != '0);
    hi.last_cycle = (rem_r == '0);
    hi.table_full = (n_r == CNT_BITS'(TABLE_DEPTH));
    hi.out_free   = out_free;
    hi.scan       = scan_r;
  end

  sit_head u_head (
    .hi (hi),
    .ho (ho)
  );

  // write-back slots: k entries already placed, rem shifts still to come
  assign scan_go = (state_r == S_SCAN) && !ho.stall;
  assign wr0     = scan_go && ho.w0_en;
  assign wr1     = scan_go && ho.w1_en;
  assign c0      = IDX_BITS'(k_r) + IDX_BITS'(rem_r);
  assign c1      = c0 + 1'b1;
  assign k_pass  = k_r + CNT_BITS'(ho.w0_en) + CNT_BITS'(ho.w1_en);

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    cell_ctl_t ctl;
    entry_t    nb;
    assign ctl = '{shift:  scan_go,
                   w0_hit: wr0 && (c0 == IDX_BITS'(i)),
                   w1_hit: wr1 && (c1 == IDX_BITS'(i))};
    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign nb = cell_q[i];
    end else begin : g_body
      assign nb = cell_q[i+1];
    end
    sit_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .shift_in (nb),
      .w0_data  (ho.w0),
      .w1_data  (ho.w1),
      .q        (cell_q[i])
    );
  end

  // next state and outputs
  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    rem_nxt       = rem_r;
    phase_nxt     = phase_r;
    op_nxt        = op_r;
    rs_nxt        = rs_r;
    rl_nxt        = rl_r;
    ro_nxt        = ro_r;
    rt_nxt        = rt_r;
    scan_nxt      = scan_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt       = action_e'(in_action);
          rs_nxt       = in_start_frame;
          rl_nxt       = in_length_frames;
          ro_nxt       = in_source_offset;
          rt_nxt       = in_entry_tag;
          phase_nxt    = 1'b0;
          k_nxt        = '0;
          rem_nxt      = (n_r == '0) ? '0 : n_r - 1'b1;
          scan_nxt     = '0;
          scan_nxt.cur = {1'b0, in_start_frame};
          case (in_action) inside
            ACT_INSERT, ACT_OVERWRITE: begin
              if (in_length_frames == '0) begin
                scan_nxt.status = ST_EMPTY;
                state_nxt       = S_FINISH;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            ACT_REMOVE, ACT_LOOKUP, ACT_FIND_FREE, ACT_NEXT_START: begin
              state_nxt = S_SCAN;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (!ho.stall) begin
          scan_nxt = ho.scan;
          k_nxt    = k_pass;
          rem_nxt  = rem_r - 1'b1;
          if (ho.emit) begin
            out_valid_nxt = 1'b1;
            res_nxt       = ho.res;
          end
          if (rem_r == '0) begin
            n_nxt = k_pass;
            if (op_r == ACT_OVERWRITE && !phase_r) begin
              // trimming done, run the insert pass on the new contents
              phase_nxt = 1'b1;
              scan_nxt  = '0;
              k_nxt     = '0;
              rem_nxt   = (k_pass == '0) ? '0 : k_pass - 1'b1;
            end else begin
              state_nxt = S_FINISH;
            end
          end
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          case (op_r) inside
            ACT_INSERT, ACT_OVERWRITE: begin
              res_nxt = status_result(scan_r.status, '0);
            end
            ACT_FIND_FREE: begin
              res_nxt = status_result(ST_OK, scan_r.cur);
            end
            default: begin
              res_nxt = scan_r.hit_valid ? entry_result(scan_r.hit, 1'b1)
                                         : status_result(ST_NONE, '0);
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r     <= k_nxt;
    rem_r   <= rem_nxt;
    phase_r <= phase_nxt;
    op_r    <= op_nxt;
    rs_r    <= rs_nxt;
    rl_r    <= rl_nxt;
    ro_r    <= ro_nxt;
    rt_r    <= rt_nxt;
    scan_r  <= scan_nxt;
    res_r   <= res_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = res_r.status;
  assign out_frame_value  = res_r.frame_value;
  assign out_found_length = res_r.found_length;
  assign out_found_offset = res_r.found_offset;
  assign out_found_tag    = res_r.found_tag;
  assign out_last         = res_r.last;

  // table never holds more entries than cells
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CNT_BITS'(TABLE_DEPTH))
    else $error("used count above table depth");

  // write-back count within a pass stays inside the chain
  a_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (k_r <= CNT_BITS'(TABLE_DEPTH)))
    else $error("write-back count overran the table");

  // a pass always ends through the result stage
  a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |=> (state_r != S_IDLE))
    else $error("pass ended without a final result");

  // the chain only stalls for a full result register during remove range
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && ho.stall) |-> (mode == M_REMOVE && out_valid_r && !out_ready))
    else $error("chain stalled without a blocked result");

endmodule

### rtl/sit_cell.sv
// one table cell: holds an entry, shifts from its right neighbor or takes a write
`timescale 1ns / 1ps
module sit_cell
  import sit_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  entry_t    shift_in,
  input  entry_t    w0_data,
  input  entry_t    w1_data,
  output entry_t    q
);

  entry_t q_r;

  always_ff @(posedge clk) begin
    if (ctl.w0_hit) begin
      q_r <= w0_data;
    end else if (ctl.w1_hit) begin
      q_r <= w1_data;
    end else if (ctl.shift) begin
      q_r <= shift_in;
    end
  end

  assign q = q_r;

endmodule

### rtl/sit_head.sv
// head unit: processes the entry leaving cell 0 for the running action
`timescale 1ns / 1ps
module sit_head
  import sit_pkg::*;
(
  input  head_in_t  hi,
  output head_out_t ho
);

  end_t   s_ext;
  end_t   req_end;
  end_t   x_end;
  end_t   cut;
  entry_t new_e;
  entry_t mod_e;
  logic   contained;
  logic   ovl;
  scan_t  sc;

  always_comb begin
    s_ext   = {1'b0, hi.req_start};
    req_end = s_ext + {1'b0, hi.req_len};
    x_end   = hi.x.start + {1'b0, hi.x.length};
    new_e   = '{start: s_ext, length: hi.req_len, offset: hi.req_off, tag: hi.req_tag};
    contained = hi.x_valid && (hi.x.start >= s_ext) && (x_end <= req_end) &&
                (hi.scan.rm_cnt < RM_BITS'(MAX_RESULTS));
    sc    = hi.scan;
    mod_e = hi.x;
    cut   = '0;
    ovl   = 1'b0;
    ho    = '0;
    ho.w0_en = hi.x_valid;
    ho.w0    = hi.x;

    case (hi.mode)
      M_INSERT: begin
        if (hi.x_valid && !sc.decided && hi.x.start >= s_ext) begin
          ovl        = (hi.x.start < req_end) || (sc.prev_end > s_ext);
          sc.decided = 1'b1;
          sc.status  = ovl ? ST_OVERLAP : (hi.table_full ? ST_FULL : ST_OK);
          if (sc.status == ST_OK) begin
            ho.w0    = new_e;
            ho.w1_en = 1'b1;
            ho.w1    = hi.x;
          end
        end else if (hi.x_valid && hi.x.start < s_ext) begin
          sc.prev_end = x_end;
        end
        // nothing starts at or after the new entry: append at the tail
        if (hi.last_cycle && !sc.decided) begin
          sc.decided = 1'b1;
          sc.status  = (sc.prev_end > s_ext) ? ST_OVERLAP :
                       (hi.table_full ? ST_FULL : ST_OK);
          if (sc.status == ST_OK) begin
            if (ho.w0_en) begin
              ho.w1_en = 1'b1;
              ho.w1    = new_e;
            end else begin
              ho.w0_en = 1'b1;
              ho.w0    = new_e;
            end
          end
        end
      end
      M_TRIM: begin
        if (contained) begin
          ho.w0_en  = 1'b0;
          sc.rm_cnt = sc.rm_cnt + 1'b1;
        end else if (hi.x.start < req_end && s_ext < x_end) begin
          if (hi.x.start < s_ext) begin
            mod_e.length = FRAME_BITS'(s_ext - hi.x.start);
          end else if (x_end > req_end) begin
            cut          = req_end - hi.x.start;
            mod_e.start  = req_end;
            mod_e.length = hi.x.length - cut[FRAME_BITS-1:0];
            mod_e.offset = hi.x.offset + cut[FRAME_BITS-1:0];
          end
          ho.w0 = mod_e;
        end
      end
      M_REMOVE: begin
        if (contained) begin
          if (sc.hit_valid && !hi.out_free) begin
            ho.stall = 1'b1;
          end else begin
            ho.w0_en = 1'b0;
            if (sc.hit_valid) begin
              ho.emit = 1'b1;
              ho.res  = entry_result(sc.hit, 1'b0);
            end
            sc.hit       = hi.x;
            sc.hit_valid = 1'b1;
            sc.rm_cnt    = sc.rm_cnt + 1'b1;
          end
        end
      end
      M_LOOKUP: begin
        if (hi.x_valid && !sc.hit_valid && hi.x.start <= s_ext && s_ext < x_end) begin
          sc.hit       = hi.x;
          sc.hit_valid = 1'b1;
        end
      end
      M_NEXT: begin
        if (hi.x_valid && !sc.hit_valid && hi.x.start >= s_ext) begin
          sc.hit       = hi.x;
          sc.hit_valid = 1'b1;
        end
      end
      M_FREE: begin
        if (hi.x_valid && !sc.done && x_end > sc.cur) begin
          if ({1'b0, hi.x.start} >= ({1'b0, sc.cur} + {2'b00, hi.req_len})) begin
            sc.done = 1'b1;
          end else begin
            sc.cur = x_end;
          end
        end
      end
      default: begin
      end
    endcase
    ho.scan = sc;
  end

endmodule
